// ===== src/pdct_pkg.sv =====
// Shared types and constants of the pulse-distance code transmitter.
package pdct_pkg;

  localparam int CODE_W         = 32;
  localparam int CODE_BITS_DEF  = 32;
  localparam int TICK_W         = 14;
  localparam int CFG_IDX_W      = 3;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

  localparam logic [TICK_W-1:0] HDR_MARK_RST   = TICK_W'(4500);
  localparam logic [TICK_W-1:0] HDR_SPACE_RST  = TICK_W'(4500);
  localparam logic [TICK_W-1:0] BIT_MARK_RST   = TICK_W'(560);
  localparam logic [TICK_W-1:0] ZERO_SPACE_RST = TICK_W'(560);
  localparam logic [TICK_W-1:0] ONE_SPACE_RST  = TICK_W'(1690);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HDR_MARK  = 3'd1,
    PH_HDR_SPACE = 3'd2,
    PH_BIT_MARK  = 3'd3,
    PH_BIT_SPACE = 3'd4,
    PH_END_MARK  = 3'd5,
    PH_END_SPACE = 3'd6
  } phase_t;

  typedef enum logic {
    KIND_SEND = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HDR_MARK   = 3'd0,
    CFG_HDR_SPACE  = 3'd1,
    CFG_BIT_MARK   = 3'd2,
    CFG_ZERO_SPACE = 3'd3,
    CFG_ONE_SPACE  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    kind_t             kind;
    logic [CODE_W-1:0] code;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic send_accepted;
  } result_t;

endpackage

// ===== src/pdct_front.sv =====
// Input side: accepts items, classifies them and queues them for the waveform engine.
module pdct_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        in_tuser,   // [0] op
  input  logic [pdct_pkg::CODE_W-1:0] in_tdata,   // [31:0] code_word
  output logic                        head_valid,
  output pdct_pkg::item_t             head,
  input  logic                        pop
);

  localparam int CNT_W = pdct_pkg::QPTR_W + 1;

  pdct_pkg::item_t                 queue_r [pdct_pkg::QUEUE_DEPTH];
  logic [pdct_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [pdct_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [CNT_W-1:0]                count_r;
  logic [CNT_W-1:0]                count_nxt;
  logic                            push;
  pdct_pkg::item_t                 item;

  assign in_tready  = (count_r != CNT_W'(pdct_pkg::QUEUE_DEPTH));
  assign push       = in_tvalid && in_tready;
  assign head_valid = (count_r != '0);
  assign head       = queue_r[rd_ptr_r];

  always_comb begin
    item.kind = in_tuser ? pdct_pkg::KIND_TICK : pdct_pkg::KIND_SEND;
    item.code = in_tdata;
  end

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + pdct_pkg::QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + pdct_pkg::QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) queue_r[wr_ptr_r] <= item;
  end

endmodule

// ===== src/pdct_back.sv =====
// Waveform engine: frame sequencer, timing registers and registered result.
module pdct_back #(
  parameter int CODE_BITS = pdct_pkg::CODE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           head_valid,
  input  pdct_pkg::item_t                head,
  output logic                           pop,
  input  logic                           cfg_valid,
  input  logic [pdct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdct_pkg::TICK_W-1:0]    cfg_data,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output pdct_pkg::result_t              out_res
);

  localparam int POS_W = $clog2(CODE_BITS);
  localparam int TW    = pdct_pkg::TICK_W;

  logic [TW-1:0] hdr_mark_r, hdr_space_r, bit_mark_r, zero_space_r, one_space_r;

  pdct_pkg::phase_t     phase_r,  phase_nxt;
  logic [POS_W-1:0]     pos_r,    pos_nxt;
  logic [CODE_BITS-1:0] shift_r,  shift_nxt;
  logic [TW-1:0]        remain_r, remain_nxt;
  logic                 line_r,   line_nxt;
  logic                 out_valid_r;
  pdct_pkg::result_t    res_r,    res_nxt;
  logic                 done;
  logic                 accepted;

  assign pop        = head_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_res    = res_r;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    shift_nxt  = shift_r;
    remain_nxt = remain_r;
    line_nxt   = line_r;
    done       = 1'b0;
    accepted   = 1'b0;
    if (head.kind == pdct_pkg::KIND_SEND) begin
      if (phase_r == pdct_pkg::PH_IDLE) begin
        shift_nxt  = CODE_BITS'(head.code);
        pos_nxt    = '0;
        phase_nxt  = pdct_pkg::PH_HDR_MARK;
        remain_nxt = hdr_mark_r;
        line_nxt   = 1'b1;
        accepted   = 1'b1;
      end
    end else if (phase_r != pdct_pkg::PH_IDLE) begin
      if (remain_r > TW'(1)) begin
        remain_nxt = remain_r - TW'(1);
      end else begin
        case (phase_r)
          pdct_pkg::PH_HDR_MARK: begin
            phase_nxt  = pdct_pkg::PH_HDR_SPACE;
            remain_nxt = hdr_space_r;
            line_nxt   = 1'b0;
          end
          pdct_pkg::PH_HDR_SPACE: begin
            phase_nxt  = pdct_pkg::PH_BIT_MARK;
            remain_nxt = bit_mark_r;
            line_nxt   = 1'b1;
          end
          pdct_pkg::PH_BIT_MARK: begin
            phase_nxt  = pdct_pkg::PH_BIT_SPACE;
            remain_nxt = shift_r[CODE_BITS-1] ? one_space_r : zero_space_r;
            line_nxt   = 1'b0;
          end
          pdct_pkg::PH_BIT_SPACE: begin
            remain_nxt = bit_mark_r;
            line_nxt   = 1'b1;
            if (pos_r == POS_W'(CODE_BITS - 1)) begin
              phase_nxt = pdct_pkg::PH_END_MARK;
            end else begin
              phase_nxt = pdct_pkg::PH_BIT_MARK;
              pos_nxt   = pos_r + POS_W'(1);
              shift_nxt = {shift_r[CODE_BITS-2:0], 1'b0};
            end
          end
          pdct_pkg::PH_END_MARK: begin
            phase_nxt  = pdct_pkg::PH_END_SPACE;
            remain_nxt = zero_space_r;
            line_nxt   = 1'b0;
          end
          default: begin
            phase_nxt  = pdct_pkg::PH_IDLE;
            remain_nxt = '0;
            line_nxt   = 1'b0;
            pos_nxt    = '0;
            done       = 1'b1;
          end
        endcase
      end
    end
    res_nxt.line_level    = line_nxt;
    res_nxt.busy_res      = (phase_nxt != pdct_pkg::PH_IDLE);
    res_nxt.frame_done    = done;
    res_nxt.send_accepted = accepted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= pdct_pkg::PH_IDLE;
      pos_r       <= '0;
      remain_r    <= '0;
      line_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r  <= phase_nxt;
        pos_r    <= pos_nxt;
        remain_r <= remain_nxt;
        line_r   <= line_nxt;
      end
      if (pop)             out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shift_r <= shift_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_mark_r   <= pdct_pkg::HDR_MARK_RST;
      hdr_space_r  <= pdct_pkg::HDR_SPACE_RST;
      bit_mark_r   <= pdct_pkg::BIT_MARK_RST;
      zero_space_r <= pdct_pkg::ZERO_SPACE_RST;
      one_space_r  <= pdct_pkg::ONE_SPACE_RST;
    end else if (cfg_valid) begin
      case (pdct_pkg::cfg_idx_t'(cfg_index))
        pdct_pkg::CFG_HDR_MARK:   hdr_mark_r   <= cfg_data;
        pdct_pkg::CFG_HDR_SPACE:  hdr_space_r  <= cfg_data;
        pdct_pkg::CFG_BIT_MARK:   bit_mark_r   <= cfg_data;
        pdct_pkg::CFG_ZERO_SPACE: zero_space_r <= cfg_data;
        pdct_pkg::CFG_ONE_SPACE:  one_space_r  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/pulse_distance_code_transmitter.sv =====
// Pulse-distance code transmitter: top level with queue, waveform engine and checks.
//
// A send item (tuser 0) starts a frame when the transmitter is idle: header mark,
// header space, CODE_BITS data bits MSB first (mark, then short or long space), and
// a closing zero bit. Each tick item (tuser 1) moves the waveform on by one tick.
// Every input item gives exactly one result item with the line level and status.
// The block takes one item per clock as long as out_tready does not hold the output;
// the input queue is 4 entries deep. With the queue empty and the output free, the
// item is registered in the input queue and its result then in the result register,
// which drives the output. Timing registers are written through the cfg port, which is always ready.
module pulse_distance_code_transmitter #(
  parameter int CODE_BITS = pdct_pkg::CODE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic                           in_tuser,   // [0] op
  input  logic [pdct_pkg::CODE_W-1:0]    in_tdata,   // [31:0] code_word
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [0] line_level, [1] busy_res,
                                                     // [2] send_accepted, [7:3] zero
  output logic                           out_tlast,  // frame_done
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pdct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdct_pkg::TICK_W-1:0]    cfg_data
);

  logic              head_valid;
  pdct_pkg::item_t   head;
  logic              pop;
  pdct_pkg::result_t res;

  assign cfg_ready = 1'b1;

  pdct_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  pdct_back #(
    .CODE_BITS (CODE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {5'b00000, res.send_accepted, res.busy_res, res.line_level};
  assign out_tlast = res.frame_done;

  a_done_ends_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tdata[0] && !out_tdata[1] && !out_tdata[2])
    else $error("frame end without idle low line");

  a_start_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[0] && out_tdata[1])
    else $error("started frame not driving header mark");

  a_mark_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("mark driven while idle");

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("engine took an item from an empty queue");

endmodule
